FILE: rtl/core/ccb_pkg.sv
// ccb_pkg: shared types, constants and helpers for the calibration binning block
// no dependencies
package ccb_pkg;

  localparam int MaxBins      = 16;
  localparam int BinW         = $clog2(MaxBins);
  localparam int HistDepth    = 1024;
  localparam int HistW        = $clog2(HistDepth);
  localparam int FillW        = HistW + 1;
  localparam int Lookback     = 50;
  localparam int LookW        = $clog2(Lookback + 1);
  localparam int ConfW        = 17;
  localparam int OneQ16       = 65536;
  localparam int HalfQ16      = 32768;
  localparam int CalMinHist   = 50;
  localparam int RecentMin    = 10;
  localparam int LimitFloor   = 5;
  localparam int DivW         = 64;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_CALIB  = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [0:0] REG_BINS  = 1'd0;
  localparam logic [0:0] REG_LIMIT = 1'd1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // latch input item
    logic do_record;   // bin update and ring push
    logic do_clear;    // reset state
    logic bin_start;   // begin bin walk
    logic bin_step;    // accumulate one bin
    logic ring_start;  // begin lookback walk
    logic ring_step;   // accumulate one ring entry
    logic div_start;   // start divider
    logic div_sel;     // 0 error division, 1 accuracy division
    logic finish;      // drive result strobe
  } ccb_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] func;
    logic       bin_last;
    logic       ring_last;
    logic       div_done;
  } ccb_sts_t;

  // smoothing: (9*old + x + 5) / 10 via reciprocal multiply with correction
  function automatic logic [ConfW-1:0] smooth(input logic [ConfW-1:0] old_v,
                                              input logic [ConfW-1:0] x_v);
    logic [21:0] num;
    logic [42:0] prod;
    logic [21:0] q;
    logic [21:0] r;
    num  = 22'(old_v) * 22'd9 + 22'(x_v) + 22'd5;
    prod = 43'(num) * 43'd419431;
    q    = 22'(prod >> 22);
    r    = num - 22'(q * 22'd10);
    if (r >= 22'd10) q = q + 22'd1;
    return ConfW'(q);
  endfunction

endpackage

FILE: rtl/core/ccb_div.sv
// ccb_div: radix-2 restoring divider, one quotient bit per cycle
// depends on ccb_pkg
module ccb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ccb_pkg::DivW-1:0]   dividend,
  input  logic [ccb_pkg::DivW-1:0]   divisor,
  output logic                       done,
  output logic [ccb_pkg::DivW-1:0]   quotient
);
  localparam int CntW = $clog2(ccb_pkg::DivW + 1);

  logic [ccb_pkg::DivW-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [ccb_pkg::DivW:0]   rem_r, rem_nxt, trial;
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt, done_r, done_nxt;

  // shift-subtract step
  always_comb begin
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[ccb_pkg::DivW-1:0], q_r[ccb_pkg::DivW-1]};
    if (start) begin
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(ccb_pkg::DivW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[ccb_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[ccb_pkg::DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

FILE: rtl/core/ccb_datapath.sv
// ccb_datapath: bin statistics, outcome ring, report accumulators and result registers
// depends on ccb_pkg and ccb_div
module ccb_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccb_pkg::ccb_cmd_t           cmd,
  output ccb_pkg::ccb_sts_t           sts,
  input  logic [1:0]                  in_func,
  input  logic [16:0]                 in_confidence,
  input  logic                        in_correct,
  input  logic [4:0]                  bins_reg,
  input  logic [10:0]                 limit_reg,
  output logic                        out_valid,
  output logic [16:0]                 out_calibrated,
  output logic [16:0]                 out_calib_error,
  output logic [16:0]                 out_recent_accuracy,
  output logic [10:0]                 out_history_size,
  output logic [31:0]                 out_update_total
);
  localparam int BinW  = ccb_pkg::BinW;
  localparam int HistW = ccb_pkg::HistW;
  localparam int FillW = ccb_pkg::FillW;
  localparam int ConfW = ccb_pkg::ConfW;
  localparam int LookW = ccb_pkg::LookW;

  // latched item
  logic [1:0]       func_r;
  logic [ConfW-1:0] conf_r;
  logic             ok_r;

  // state
  logic [ConfW-1:0] mconf_r [ccb_pkg::MaxBins];
  logic [ConfW-1:0] macc_r  [ccb_pkg::MaxBins];
  logic [31:0]      hits_r  [ccb_pkg::MaxBins];
  logic             ring_mem [ccb_pkg::HistDepth];
  logic [HistW-1:0] head_r;
  logic [FillW-1:0] fill_r;
  logic [31:0]      rcnt_r;

  // effective register values
  logic [BinW:0]  nb;
  logic [FillW-1:0] lim;
  always_comb begin
    if (bins_reg == 5'd0) nb = (BinW+1)'(1);
    else if (32'(bins_reg) > ccb_pkg::MaxBins) nb = (BinW+1)'(ccb_pkg::MaxBins);
    else nb = (BinW+1)'(bins_reg);
    if (32'(limit_reg) < ccb_pkg::LimitFloor) lim = FillW'(ccb_pkg::LimitFloor);
    else if (32'(limit_reg) > ccb_pkg::HistDepth) lim = FillW'(ccb_pkg::HistDepth);
    else lim = FillW'(limit_reg);
  end

  // saturation and binning of the incoming confidence, registered at load
  logic [ConfW-1:0]    conf_sat;
  logic [ConfW+BinW:0] bprod;
  logic [BinW:0]       bidx_w;
  logic [BinW-1:0]     bidx_r;
  always_comb begin
    conf_sat = (in_confidence > 17'(ccb_pkg::OneQ16)) ? 17'(ccb_pkg::OneQ16)
                                                      : in_confidence;
    bprod  = (ConfW+BinW+1)'(conf_sat) * (ConfW+BinW+1)'(nb);
    bidx_w = (BinW+1)'(bprod >> 16);
    if (bidx_w >= nb) bidx_w = nb - (BinW+1)'(1);
  end

  // prune and push arithmetic (limit/5 via reciprocal)
  logic [FillW-1:0] drop;
  logic [FillW+15:0] dprod;
  logic [FillW-1:0] fill_pr;
  logic [HistW-1:0] head_pr;
  logic [HistW-1:0] wr_addr;
  always_comb begin
    dprod = (FillW+16)'(lim) * (FillW+16)'(13108);
    drop  = FillW'(dprod >> 16);
    if (drop > fill_r) drop = fill_r;
    if (fill_r + FillW'(1) > lim) begin
      fill_pr = fill_r - drop;
      head_pr = head_r + drop[HistW-1:0];
    end else begin
      fill_pr = fill_r;
      head_pr = head_r;
    end
    wr_addr = head_pr + fill_pr[HistW-1:0];
  end

  // report walk
  logic [BinW-1:0]  bi_r;
  logic [63:0]      esum_r;
  logic [63:0]      etot_r;
  logic [31:0]      hit_sel;
  logic [ConfW-1:0] gap;
  logic [48:0]      gprod;
  logic [LookW-1:0] lb_r;
  logic [LookW-1:0] rk_r;
  logic [HistW-1:0] raddr_r;
  logic             rd_r;
  logic             rd_v_r;
  logic [LookW-1:0] rhits_r;
  logic [16:0]      err_r;
  logic [16:0]      acc_r;
  logic [ccb_pkg::DivW-1:0] div_a, div_b, div_q;
  logic             div_done;

  always_comb begin
    hit_sel = hits_r[bi_r];
    gap = (mconf_r[bi_r] > macc_r[bi_r]) ? mconf_r[bi_r] - macc_r[bi_r]
                                         : macc_r[bi_r] - mconf_r[bi_r];
    gprod = 49'(gap) * 49'(hit_sel);
    if (!cmd.div_sel) begin
      div_a = esum_r + (etot_r >> 1);
      div_b = etot_r;
    end else begin
      div_a = 64'(rhits_r) * 64'(ccb_pkg::OneQ16) + 64'(lb_r >> 1);
      div_b = 64'(lb_r);
    end
  end

  ccb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // ring memory, written and read in a clocked block
  always_ff @(posedge clk) begin
    if (cmd.do_record) ring_mem[wr_addr] <= ok_r;
    rd_r <= ring_mem[raddr_r];
  end

  logic [LookW-1:0] lb_w;
  always_comb begin
    lb_w = (fill_r < FillW'(ccb_pkg::Lookback)) ? LookW'(fill_r)
                                                : LookW'(ccb_pkg::Lookback);
  end

  logic valid_r;
  logic [16:0] cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      rcnt_r  <= '0;
      valid_r <= 1'b0;
      rd_v_r  <= 1'b0;
      for (int i = 0; i < ccb_pkg::MaxBins; i++) begin
        mconf_r[i] <= '0;
        macc_r[i]  <= '0;
        hits_r[i]  <= '0;
      end
    end else begin
      valid_r <= cmd.finish;
      rd_v_r  <= cmd.ring_step;
      if (cmd.do_clear) begin
        head_r <= '0;
        fill_r <= '0;
        rcnt_r <= '0;
        for (int i = 0; i < ccb_pkg::MaxBins; i++) begin
          mconf_r[i] <= '0;
          macc_r[i]  <= '0;
          hits_r[i]  <= '0;
        end
      end else if (cmd.do_record) begin
        head_r <= head_pr;
        fill_r <= fill_pr + FillW'(1);
        rcnt_r <= rcnt_r + 32'd1;
        mconf_r[bidx_r] <= ccb_pkg::smooth(mconf_r[bidx_r], conf_r);
        macc_r[bidx_r]  <= ccb_pkg::smooth(macc_r[bidx_r],
                                           ok_r ? ConfW'(ccb_pkg::OneQ16) : '0);
        hits_r[bidx_r]  <= hits_r[bidx_r] + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      conf_r <= conf_sat;
      bidx_r <= bidx_w[BinW-1:0];
      ok_r   <= in_correct;
      cal_r  <= '0;
      err_r  <= '0;
      acc_r  <= '0;
    end
    // calibrate lookup in the cycle after load
    if (cmd.do_record == 1'b0 && func_r == ccb_pkg::FUNC_CALIB && cmd.finish) begin
      if (fill_r >= FillW'(ccb_pkg::CalMinHist) && hits_r[bidx_r] != 32'd0)
        cal_r <= macc_r[bidx_r];
      else
        cal_r <= conf_r;
    end
    if (cmd.bin_start) begin
      bi_r   <= '0;
      esum_r <= '0;
      etot_r <= '0;
    end else if (cmd.bin_step) begin
      if ((BinW+1)'(bi_r) < nb && hit_sel != 32'd0) begin
        esum_r <= esum_r + 64'(gprod);
        etot_r <= etot_r + 64'(hit_sel);
      end
      bi_r <= bi_r + BinW'(1);
    end
    if (cmd.ring_start) begin
      lb_r    <= lb_w;
      rk_r    <= '0;
      rhits_r <= '0;
      raddr_r <= head_r + HistW'(fill_r - FillW'(lb_w));
    end else if (cmd.ring_step) begin
      rk_r    <= rk_r + LookW'(1);
      raddr_r <= raddr_r + HistW'(1);
    end
    if (rd_v_r) rhits_r <= rhits_r + LookW'(rd_r);
    if (div_done) begin
      if (!cmd.div_sel) begin
        if (fill_r == '0 || etot_r == 64'd0) err_r <= '0;
        else if (div_q > 64'(ccb_pkg::OneQ16)) err_r <= 17'(ccb_pkg::OneQ16);
        else err_r <= div_q[16:0];
      end else begin
        if (fill_r < FillW'(ccb_pkg::RecentMin)) acc_r <= 17'(ccb_pkg::HalfQ16);
        else acc_r <= div_q[16:0];
      end
    end
  end

  // the walk covers all physical bins; the last index ends it
  assign sts.func      = func_r;
  assign sts.bin_last  = (bi_r == BinW'(ccb_pkg::MaxBins - 1));
  assign sts.ring_last = (rk_r + LookW'(1) >= lb_r) || (lb_r == '0);
  assign sts.div_done  = div_done;

  assign out_valid           = valid_r;
  assign out_calibrated      = cal_r;
  assign out_calib_error     = err_r;
  assign out_recent_accuracy = acc_r;
  assign out_history_size    = fill_r;
  assign out_update_total    = rcnt_r;
endmodule

FILE: rtl/core/ccb_ctrl.sv
// ccb_ctrl: sequencer for record, calibrate, report and clear transactions
// depends on ccb_pkg
module ccb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output ccb_pkg::ccb_cmd_t  cmd,
  input  ccb_pkg::ccb_sts_t  sts
);
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DEC   = 10'b0000000010,
    S_BINS  = 10'b0000000100,
    S_EDIV  = 10'b0000001000,
    S_EWAIT = 10'b0000010000,
    S_RING  = 10'b0000100000,
    S_RDRN  = 10'b0001000000,
    S_ADIV  = 10'b0010000000,
    S_AWAIT = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.func)
          ccb_pkg::FUNC_RECORD: begin
            cmd.do_record = 1'b1;
            state_nxt     = S_DONE;
          end
          ccb_pkg::FUNC_CLEAR: begin
            cmd.do_clear = 1'b1;
            state_nxt    = S_DONE;
          end
          ccb_pkg::FUNC_REPORT: begin
            cmd.bin_start = 1'b1;
            state_nxt     = S_BINS;
          end
          default: begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        endcase
      end
      S_BINS: begin
        cmd.bin_step = 1'b1;
        if (sts.bin_last) state_nxt = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_EWAIT;
      end
      S_EWAIT: begin
        if (sts.div_done) begin
          cmd.ring_start = 1'b1;
          state_nxt      = S_RING;
        end
      end
      S_RING: begin
        cmd.div_sel   = 1'b1;
        cmd.ring_step = 1'b1;
        if (sts.ring_last) begin
          drain_nxt = 1'b0;
          state_nxt = S_RDRN;
        end
      end
      S_RDRN: begin
        cmd.div_sel = 1'b1;
        drain_nxt   = 1'b1;
        if (drain_r) state_nxt = S_ADIV;
      end
      S_ADIV: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_AWAIT;
      end
      S_AWAIT: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

FILE: rtl/core/confidence_calibration_bins.sv
// confidence_calibration_bins: calibration binning top level with apb register port
// depends on ccb_pkg, ccb_ctrl, ccb_datapath
// record and clear go through a done state before the strobe; calibrate finishes from decode
// report: bin walk, serial error division, lookback walk over up to 50 newest outcomes, drain,
// serial accuracy division; one transaction at a time, busy high until the strobe
// synchronous active-low reset clears all statistics and loads bins 10, limit 1000
module confidence_calibration_bins (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [16:0] in_confidence,
  input  logic        in_correct,
  output logic        out_valid,
  output logic [16:0] out_calibrated,
  output logic [16:0] out_calib_error,
  output logic [16:0] out_recent_accuracy,
  output logic [10:0] out_history_size,
  output logic [31:0] out_update_total,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [4:0]  bins_r;
  logic [10:0] limit_r;
  ccb_pkg::ccb_cmd_t cmd;
  ccb_pkg::ccb_sts_t sts;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r  <= 5'd10;
      limit_r <= 11'd1000;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == ccb_pkg::REG_BINS) bins_r <= pwdata[4:0];
      else if (paddr[2] == ccb_pkg::REG_LIMIT) limit_r <= pwdata[10:0];
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == ccb_pkg::REG_BINS) prdata = 32'(bins_r);
      else prdata = 32'(limit_r);
    end
  end
  assign pready = 1'b1;

  ccb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  ccb_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_func             (in_func),
    .in_confidence       (in_confidence),
    .in_correct          (in_correct),
    .bins_reg            (bins_r),
    .limit_reg           (limit_r),
    .out_valid           (out_valid),
    .out_calibrated      (out_calibrated),
    .out_calib_error     (out_calib_error),
    .out_recent_accuracy (out_recent_accuracy),
    .out_history_size    (out_history_size),
    .out_update_total    (out_update_total)
  );
endmodule

FILE: rtl/core/ccb_checker.sv
// ccb_checker: port-level checks for the calibration binning block, bound to the top level
// depends on confidence_calibration_bins ports only
module ccb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [16:0] out_calibrated,
  input logic [16:0] out_calib_error,
  input logic [16:0] out_recent_accuracy,
  input logic [10:0] out_history_size
);
  // accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");
  // result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe held");
  // strobe only after busy
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("strobe without transaction");
  // values in range
  a_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_calibrated <= 17'd65536 && out_calib_error <= 17'd65536
      && out_recent_accuracy <= 17'd65536 && out_history_size <= 11'd1024)
    else $error("result out of range");
endmodule

bind confidence_calibration_bins ccb_checker u_ccb_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_calibrated      (out_calibrated),
  .out_calib_error     (out_calib_error),
  .out_recent_accuracy (out_recent_accuracy),
  .out_history_size    (out_history_size)
);

FILE: tb/sv/confidence_calibration_bins_tb.sv
// confidence_calibration_bins_tb: self-checking bench for the calibration binning block
// keeps its own calibration statistics and compares every result strobe against them
// depends on ccb_pkg and confidence_calibration_bins
`timescale 1ns / 100ps

module confidence_calibration_bins_tb;

  localparam int CycleLimit = 800000;

  typedef struct {
    logic [1:0]  func;
    logic [16:0] conf;
    logic        correct;
  } calib_item_t;

  typedef struct {
    logic [16:0] calibrated;
    logic [16:0] calib_error;
    logic [16:0] recent_accuracy;
    logic [10:0] history_size;
    logic [31:0] update_total;
  } calib_result_t;

  // statistics tracker and result checker
  class calib_scoreboard;
    int unsigned bins_reg = 10;
    int unsigned limit_reg = 1000;
    int unsigned mean_conf[ccb_pkg::MaxBins];
    int unsigned mean_acc[ccb_pkg::MaxBins];
    int unsigned hits[ccb_pkg::MaxBins];
    bit          outcomes[ccb_pkg::HistDepth];
    int unsigned oldest, fill;
    int unsigned records;
    calib_result_t pending_results[$];
    int errors;

    function void wipe();
      for (int i = 0; i < ccb_pkg::MaxBins; i++) begin
        mean_conf[i] = 0;
        mean_acc[i] = 0;
        hits[i] = 0;
      end
      for (int i = 0; i < ccb_pkg::HistDepth; i++) outcomes[i] = 0;
      oldest = 0;
      fill = 0;
      records = 0;
    endfunction

    function void set_reg(logic [0:0] idx, int unsigned v);
      if (idx == ccb_pkg::REG_BINS) bins_reg = v & 'h1f;
      else limit_reg = v & 'h7ff;
    endfunction

    function int unsigned used_bins();
      if (bins_reg == 0) return 1;
      if (bins_reg > ccb_pkg::MaxBins) return ccb_pkg::MaxBins;
      return bins_reg;
    endfunction

    function int unsigned bin_index(int unsigned c);
      longint unsigned idx;
      idx = (longint'(c) * used_bins()) >> 16;
      return idx >= used_bins() ? used_bins() - 1 : int'(idx);
    endfunction

    function int unsigned ewma(int unsigned old_v, int unsigned x);
      return (9 * old_v + x + 5) / 10;
    endfunction

    // note an accepted input and queue the result it must produce
    function void note_item(calib_item_t it);
      calib_result_t r;
      int unsigned c, lim, drop, b, lb, ones;
      longint unsigned sum, total, gap;
      c = (it.conf > ccb_pkg::OneQ16) ? ccb_pkg::OneQ16 : it.conf;
      r.calibrated = 0;
      r.calib_error = 0;
      r.recent_accuracy = 0;
      case (it.func)
        ccb_pkg::FUNC_RECORD: begin
          lim = (limit_reg < ccb_pkg::LimitFloor) ? ccb_pkg::LimitFloor :
                (limit_reg > ccb_pkg::HistDepth) ? ccb_pkg::HistDepth : limit_reg;
          // prune the oldest fifth once history would pass the limit
          if (fill + 1 > lim) begin
            drop = lim / 5;
            if (drop > fill) drop = fill;
            oldest = (oldest + drop) % ccb_pkg::HistDepth;
            fill -= drop;
          end
          outcomes[(oldest + fill) % ccb_pkg::HistDepth] = it.correct;
          fill++;
          b = bin_index(c);
          mean_conf[b] = ewma(mean_conf[b], c);
          mean_acc[b] = ewma(mean_acc[b], it.correct ? ccb_pkg::OneQ16 : 0);
          hits[b]++;
          records++;
        end
        ccb_pkg::FUNC_CALIB: begin
          r.calibrated = 17'(c);
          if (fill >= ccb_pkg::CalMinHist && hits[bin_index(c)] != 0)
            r.calibrated = 17'(mean_acc[bin_index(c)]);
        end
        ccb_pkg::FUNC_REPORT: begin
          // hit-weighted mean gap over the bins in use
          sum = 0;
          total = 0;
          if (fill != 0) begin
            for (int i = 0; i < used_bins(); i++) begin
              if (hits[i] != 0) begin
                gap = (mean_conf[i] > mean_acc[i]) ? mean_conf[i] - mean_acc[i]
                                                   : mean_acc[i] - mean_conf[i];
                sum += gap * hits[i];
                total += hits[i];
              end
            end
          end
          if (total != 0) begin
            gap = (sum + total / 2) / total;
            r.calib_error = (gap > ccb_pkg::OneQ16) ? 17'(ccb_pkg::OneQ16) : 17'(gap);
          end
          // accuracy over the newest outcomes
          if (fill < ccb_pkg::RecentMin) begin
            r.recent_accuracy = 17'(ccb_pkg::HalfQ16);
          end else begin
            lb = (fill < ccb_pkg::Lookback) ? fill : ccb_pkg::Lookback;
            ones = 0;
            for (int k = int'(fill - lb); k < fill; k++)
              ones += outcomes[(oldest + k) % ccb_pkg::HistDepth];
            r.recent_accuracy = 17'((longint'(ones) * ccb_pkg::OneQ16 + lb / 2) / lb);
          end
        end
        default: wipe();
      endcase
      r.history_size = 11'(fill);
      r.update_total = records;
      pending_results = {pending_results, r};
    endfunction

    function void cmp(string field, longint unsigned e, longint unsigned a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
        errors++;
      end
    endfunction

    // compare one result strobe with the oldest expectation
    function void check_result(calib_result_t a);
      calib_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual history_size %0d",
                 $time, a.history_size);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      cmp("calibrated", e.calibrated, a.calibrated);
      cmp("calib_error", e.calib_error, a.calib_error);
      cmp("recent_accuracy", e.recent_accuracy, a.recent_accuracy);
      cmp("history_size", e.history_size, a.history_size);
      cmp("update_total", e.update_total, a.update_total);
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_func = ccb_pkg::FUNC_RECORD;
  logic [16:0] in_confidence = 0;
  logic        in_correct = 0;
  logic        out_valid;
  logic [16:0] out_calibrated, out_calib_error, out_recent_accuracy;
  logic [10:0] out_history_size;
  logic [31:0] out_update_total;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  calib_scoreboard sb = new();
  int unsigned cycles = 0;

  confidence_calibration_bins u_top (
    .clk, .rst_n, .start, .busy, .in_func, .in_confidence, .in_correct,
    .out_valid, .out_calibrated, .out_calib_error, .out_recent_accuracy,
    .out_history_size, .out_update_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{out_calibrated, out_calib_error, out_recent_accuracy,
                        out_history_size, out_update_total});
  end

  // register write, setup then access phase, then back to idle
  task automatic write_reg(logic [0:0] idx, int unsigned v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'(4 * idx);
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, v);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk);
  endtask

  // present one transaction and hold it until accepted
  task automatic send(calib_item_t it, int idle_pct);
    start <= 1;
    in_func <= it.func;
    in_confidence <= it.conf;
    in_correct <= it.correct;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic calib_item_t rand_item();
    calib_item_t it;
    int unsigned p, q;
    p = $urandom_range(99);
    it.func = (p < 62) ? ccb_pkg::FUNC_RECORD : (p < 82) ? ccb_pkg::FUNC_CALIB :
              (p < 98) ? ccb_pkg::FUNC_REPORT : ccb_pkg::FUNC_CLEAR;
    q = $urandom_range(99);
    if (q < 10) it.conf = 17'($urandom_range(0, 131071));
    else if (q < 16) it.conf = ($urandom_range(1)) ? 17'd65536 : 17'd0;
    else it.conf = 17'($urandom_range(0, ccb_pkg::OneQ16));
    it.correct = 1'($urandom_range(1));
    return it;
  endfunction

  int unsigned phase_bins[8]  = '{10, 1, 16, 0, 31, 7, 3, 16};
  int unsigned phase_limit[8] = '{1000, 5, 1024, 3, 2047, 60, 17, 200};
  calib_item_t directed[$];

  initial begin
    int idle_pct;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes, every function, saturation, short history cases
    directed = '{
      '{ccb_pkg::FUNC_REPORT, 17'd0, 1'b0}, '{ccb_pkg::FUNC_CALIB, 17'd1234, 1'b0},
      '{ccb_pkg::FUNC_RECORD, 17'd0, 1'b0}, '{ccb_pkg::FUNC_RECORD, 17'd65536, 1'b1},
      '{ccb_pkg::FUNC_RECORD, 17'h1ffff, 1'b1}, '{ccb_pkg::FUNC_RECORD, 17'd32768, 1'b0},
      '{ccb_pkg::FUNC_RECORD, 17'd65535, 1'b1}, '{ccb_pkg::FUNC_CALIB, 17'd65536, 1'b0},
      '{ccb_pkg::FUNC_CALIB, 17'h1ffff, 1'b1}, '{ccb_pkg::FUNC_REPORT, 17'd0, 1'b0},
      '{ccb_pkg::FUNC_RECORD, 17'd6553, 1'b1}, '{ccb_pkg::FUNC_RECORD, 17'd6554, 1'b0},
      '{ccb_pkg::FUNC_RECORD, 17'd13107, 1'b1}, '{ccb_pkg::FUNC_RECORD, 17'd58982, 1'b1},
      '{ccb_pkg::FUNC_RECORD, 17'd1, 1'b0}, '{ccb_pkg::FUNC_RECORD, 17'd40000, 1'b1},
      '{ccb_pkg::FUNC_REPORT, 17'd0, 1'b0}, '{ccb_pkg::FUNC_CLEAR, 17'd0, 1'b0},
      '{ccb_pkg::FUNC_REPORT, 17'h1ffff, 1'b1}, '{ccb_pkg::FUNC_CALIB, 17'd0, 1'b0}
    };
    foreach (directed[i]) send(directed[i], 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ccb_pkg::REG_BINS, phase_bins[ph]);
      write_reg(ccb_pkg::REG_LIMIT, phase_limit[ph]);
      idle_pct = (ph < 3) ? 24 : (ph < 6) ? 49 : 0;
      repeat (117) send(rand_item(), idle_pct);
      drain();
    end

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
